### rtl/dq_pkg.sv
package dq_pkg;

    localparam int WORD_BITS = 32;
    localparam int FUNC_W    = 3;
    localparam int OCC_W     = 5;

    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DUMP       = 3'd4;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [FUNC_W-1:0]           func;
        logic signed [WORD_BITS-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] out_value;
        status_t                     status;
        logic [OCC_W-1:0]            occupancy;
        logic                        last;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic commit;
        logic dump_next;
    } dq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic last;
    } dq_stat_t;

endpackage

### rtl/dq_ctrl.sv
module dq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  dq_pkg::dq_stat_t  stat,
    output dq_pkg::dq_cmd_t   cmd
);

    dq_pkg::state_t state_reg;
    dq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            dq_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = dq_pkg::ST_EXEC;
                end
            end
            dq_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = dq_pkg::ST_RESP;
            end
            dq_pkg::ST_RESP:
            begin
                // wait for the output register to drain before committing
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    if (stat.last)
                    begin
                        state_next = dq_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.dump_next = 1'b1;
                        state_next    = dq_pkg::ST_EXEC;
                    end
                end
            end
            default:
            begin
                state_next = dq_pkg::ST_IDLE;
            end
        endcase
    end

    a_resp_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dq_pkg::ST_RESP && stat.out_free && !stat.last)
            |=> state_reg == dq_pkg::ST_EXEC)
        else $error("dump did not continue");

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dq_pkg::ST_EXEC) |=> state_reg == dq_pkg::ST_RESP)
        else $error("exec state held");

endmodule

### rtl/dq_datapath.sv
module dq_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dq_pkg::req_t      req,
    input  dq_pkg::dq_cmd_t   cmd,
    output dq_pkg::dq_stat_t  stat,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output dq_pkg::rsp_t      rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [dq_pkg::WORD_BITS-1:0] mem [CAPACITY];

    logic [dq_pkg::FUNC_W-1:0]    op_reg;
    logic [dq_pkg::WORD_BITS-1:0] val_reg;
    logic [IW-1:0]                front_reg;
    logic [IW-1:0]                front_next;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                idx_reg;
    logic [dq_pkg::WORD_BITS-1:0] rd_data_reg;
    logic                         out_valid_reg;
    dq_pkg::rsp_t                 out_reg;
    dq_pkg::rsp_t                 out_next;

    logic          full;
    logic          empty;
    logic          is_push;
    logic          is_pop;
    logic          push_ok;
    logic          pop_ok;
    logic          dump_ok;
    logic          mem_we;
    logic [IW-1:0] addr;
    logic [IW-1:0] front_dec;
    logic [IW-1:0] front_inc;

    function automatic logic [IW-1:0] ring_add(logic [IW-1:0] a, logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(CAPACITY))
        begin
            s = s - (CW+1)'(CAPACITY);
        end
        return s[IW-1:0];
    endfunction

    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign is_push = (op_reg == dq_pkg::FN_PUSH_FRONT) || (op_reg == dq_pkg::FN_PUSH_BACK);
    assign is_pop  = (op_reg == dq_pkg::FN_POP_FRONT) || (op_reg == dq_pkg::FN_POP_BACK);
    assign push_ok = is_push && !full;
    assign pop_ok  = is_pop && !empty;
    assign dump_ok = (op_reg == dq_pkg::FN_DUMP) && !empty;

    assign front_dec = (front_reg == '0) ? IW'(CAPACITY - 1) : front_reg - IW'(1);
    assign front_inc = ring_add(front_reg, CW'(1));

    always_comb
    begin
        case (op_reg)
            dq_pkg::FN_PUSH_FRONT: addr = front_dec;
            dq_pkg::FN_PUSH_BACK:  addr = ring_add(front_reg, count_reg);
            dq_pkg::FN_POP_BACK:   addr = ring_add(front_reg, count_reg - CW'(1));
            dq_pkg::FN_DUMP:       addr = ring_add(front_reg, idx_reg);
            default:               addr = front_reg;
        endcase
    end

    assign mem_we = cmd.exec && push_ok;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr] <= val_reg;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        if (push_ok)
        begin
            count_next = count_reg + CW'(1);
            if (op_reg == dq_pkg::FN_PUSH_FRONT)
            begin
                front_next = front_dec;
            end
        end
        else if (pop_ok)
        begin
            count_next = count_reg - CW'(1);
            if (op_reg == dq_pkg::FN_POP_FRONT)
            begin
                front_next = front_inc;
            end
        end
    end

    assign stat.last     = !dump_ok || (CW'(idx_reg + CW'(1)) == count_reg);
    assign stat.out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        out_next.out_value = (pop_ok || dump_ok) ? rd_data_reg : '0;
        out_next.occupancy = dq_pkg::OCC_W'(count_next);
        out_next.last      = stat.last;
        if (is_push && full)
        begin
            out_next.status = dq_pkg::STAT_FULL;
        end
        else if ((is_pop || op_reg == dq_pkg::FN_DUMP) && empty)
        begin
            out_next.status = dq_pkg::STAT_EMPTY;
        end
        else
        begin
            out_next.status = dq_pkg::STAT_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.func;
            val_reg <= req.push_value;
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.dump_next)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.commit)
            begin
                front_reg     <= front_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CW+1)'(front_reg) < (CW+1)'(CAPACITY))
        else $error("front index out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && rsp_stall))
        else $error("pending result overwritten");

    a_dump_index: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && dump_ok) |-> idx_reg < count_reg)
        else $error("dump index past last entry");

endmodule

### rtl/double_ended_queue_core.sv
// Deque of signed words in a ring of CAPACITY slots (front index plus entry count).
// Push or pop: accept, slot read/write, result commit; the next item is accepted only after the commit.
// Dump of n entries: one accept, then a slot read and a result commit for each entry in turn.
// A new item is taken while the previous result still waits in the output register.
// Reset clears front index, entry count, state and output valid; slot contents are not cleared.
module double_ended_queue_core #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dq_pkg::req_t  req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dq_pkg::rsp_t  rsp
);

    dq_pkg::dq_cmd_t  cmd;
    dq_pkg::dq_stat_t stat;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    dq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
